>>> design/odp_pkg.sv
package odp_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int FREQ_W        = 32;
    localparam int VCO_W         = 34;
    localparam int HS_W          = 11;
    localparam int SHIFT_W       = 3;
    localparam int FB_W          = 43;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 34;

    localparam logic [FREQ_W-1:0] REF_RESET     = 32'd152600000;
    localparam logic [VCO_W-1:0]  VCO_MIN_RESET = 34'd10800000000;
    localparam logic [VCO_W-1:0]  VCO_MAX_RESET = 34'd12206718160;

    localparam logic [HS_W-1:0]    HS_MIN        = 11'd5;
    localparam logic [HS_W-1:0]    HS_MAX        = 11'd2046;
    localparam logic [HS_W-1:0]    HS_EVEN_ABOVE = 11'd33;
    localparam logic [SHIFT_W-1:0] SHIFT_LAST    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_REF     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VCO_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VCO_MAX = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV0,
        ST_MUL,
        ST_CMP,
        ST_DIV1,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } t_div_stat;

endpackage

>>> design/odp_div.sv
module odp_div #(
    parameter int DW = 66,
    parameter int CW = $clog2(DW + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DW-1:0]               i_dividend,
    input  logic [odp_pkg::FREQ_W-1:0]  i_divisor,
    input  logic [CW-1:0]               i_nbits,
    output logic [DW-1:0]               o_quotient,
    output odp_pkg::t_div_stat          o_stat
);
    import odp_pkg::*;

    logic [DW-1:0]     r_num;
    logic [DW-1:0]     r_quo;
    logic [FREQ_W-1:0] r_rem;
    logic [FREQ_W-1:0] r_dvs;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [FREQ_W:0]   t_part;
    logic              ge;
    logic [FREQ_W:0]   diff;

    always_comb begin
        t_part = {r_rem, r_num[DW-1]};
        ge     = t_part >= {1'b0, r_dvs};
        diff   = t_part - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_quo <= '0;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= i_nbits;
        end else if (r_busy) begin
            r_num <= {r_num[DW-2:0], 1'b0};
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? diff[FREQ_W-1:0] : t_part[FREQ_W-1:0];
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_quotient    = r_quo;
    assign o_stat.done   = r_done;
    assign o_stat.rem_nz = r_rem != '0;

endmodule

>>> design/oscillator_divider_planner.sv
// Output-divider planner for a fractional-N synthesizer.
// Input channel (i_in_valid / o_in_ready) takes one beat: the requested
// output frequency. Output channel (o_out_valid / i_out_ready) returns one
// beat per input: found flag, low-speed shift code, high-speed divider and
// the 11.FRAC_BITS feedback divider. A zero frequency or no passing shift
// gives found low and all other fields zero.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes reference
// frequency (index 0), VCO lower bound (1) and VCO upper bound (2); other
// indexes are dropped. Write only while the block is idle.
// Sequence: one serial restoring division of 34 quotient bits for the
// ceiling of vco_min / freq, a multiply and a compare per tried shift
// (shifts 0 to 5, in order), then a second serial division of 34 + FRAC_BITS
// bits for vco / ref. A zero frequency skips both divisions, and the second
// is skipped if no shift passes. Both divisions share one bit-per-cycle
// divider, which sets the rate; one item is worked on at a time.
// A finished beat sits in the output register while the receiver stalls;
// the next input is taken meanwhile and its result waits until the output
// register frees. Reset loads the default registers and empties the block.
module oscillator_divider_planner #(
    parameter int FRAC_BITS = odp_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [odp_pkg::FREQ_W-1:0]      i_target_freq_hz,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_found,
    output logic [odp_pkg::SHIFT_W-1:0]     o_low_div_shift,
    output logic [odp_pkg::HS_W-1:0]        o_high_div,
    output logic [odp_pkg::FB_W-1:0]        o_feedback_div,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [odp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [odp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import odp_pkg::*;

    localparam int DW  = VCO_W + FRAC_BITS;
    localparam int CW  = $clog2(DW + 1);
    localparam int FBQ = HS_W + FRAC_BITS;

    t_state r_state, n_state;

    logic [FREQ_W-1:0]  r_ref;
    logic [VCO_W-1:0]   r_vmin;
    logic [VCO_W-1:0]   r_vmax;
    logic [FREQ_W-1:0]  r_freq;
    logic [VCO_W:0]     r_q0;
    logic [SHIFT_W-1:0] r_shift;
    logic [HS_W-1:0]    r_hs;
    logic               r_hs_ok;
    logic [FB_W-1:0]    r_prod;
    logic               r_found;
    logic [FB_W-1:0]    r_fb;

    logic               r_o_valid;
    logic               r_o_found;
    logic [SHIFT_W-1:0] r_o_shift;
    logic [HS_W-1:0]    r_o_hs;
    logic [FB_W-1:0]    r_o_fb;

    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic [FREQ_W-1:0]  div_divisor;
    logic [CW-1:0]      div_nbits;
    logic [DW-1:0]      div_quo;
    t_div_stat          div_stat;

    logic               in_acc;
    logic [VCO_W+1:0]   hs_sum;
    logic [VCO_W+1:0]   hs_c;
    logic [VCO_W+2:0]   hs_b;
    logic               hs_ok;
    logic [FB_W-1:0]    prod;
    logic [FB_W+4:0]    vco;
    logic               pass;
    logic               load_out;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = r_state == ST_IDLE;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref  <= REF_RESET;
            r_vmin <= VCO_MIN_RESET;
            r_vmax <= VCO_MAX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REF:     r_ref  <= i_cfg_data[FREQ_W-1:0];
                CFG_VCO_MIN: r_vmin <= i_cfg_data[VCO_W-1:0];
                CFG_VCO_MAX: r_vmax <= i_cfg_data[VCO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        hs_sum = {1'b0, r_q0} + ((VCO_W+2)'(1) << r_shift) - (VCO_W+2)'(1);
        hs_c   = hs_sum >> r_shift;
        if (hs_c > (VCO_W+2)'(HS_EVEN_ABOVE) && hs_c[0]) begin
            hs_b = {1'b0, hs_c} + (VCO_W+3)'(1);
        end else begin
            hs_b = {1'b0, hs_c};
        end
        hs_ok = hs_b >= (VCO_W+3)'(HS_MIN) && hs_b <= (VCO_W+3)'(HS_MAX);
        prod  = r_freq * hs_b[HS_W-1:0];
        vco   = (FB_W+5)'(r_prod) << r_shift;
        pass  = r_hs_ok && vco >= (FB_W+5)'(r_vmin) && vco <= (FB_W+5)'(r_vmax);
    end

    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = {r_vmin, {FRAC_BITS{1'b0}}};
        div_divisor  = i_target_freq_hz;
        div_nbits    = CW'(VCO_W);
        load_out     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_target_freq_hz == '0) begin
                        n_state = ST_FIN;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_DIV0;
                    end
                end
            end
            ST_DIV0: begin
                if (div_stat.done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                div_dividend = {vco[VCO_W-1:0], {FRAC_BITS{1'b0}}};
                div_divisor  = r_ref;
                div_nbits    = CW'(DW);
                if (pass) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV1;
                end else if (r_shift == SHIFT_LAST) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DIV1: begin
                if (div_stat.done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_o_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_freq  <= i_target_freq_hz;
            r_shift <= '0;
            r_found <= 1'b0;
        end
        if (r_state == ST_DIV0 && div_stat.done) begin
            r_q0 <= {1'b0, div_quo[VCO_W-1:0]} + (VCO_W+1)'(div_stat.rem_nz);
        end
        if (r_state == ST_MUL) begin
            r_hs    <= hs_b[HS_W-1:0];
            r_hs_ok <= hs_ok;
            r_prod  <= prod;
        end
        if (r_state == ST_CMP && !pass && r_shift != SHIFT_LAST) begin
            r_shift <= r_shift + SHIFT_W'(1);
        end
        if (r_state == ST_DIV1 && div_stat.done) begin
            r_found <= 1'b1;
            r_fb    <= FB_W'(div_quo[FBQ-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_found <= r_found;
            r_o_shift <= r_found ? r_shift : '0;
            r_o_hs    <= r_found ? r_hs : '0;
            r_o_fb    <= r_found ? r_fb : '0;
        end
    end

    odp_div #(
        .DW (DW),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_nbits    (div_nbits),
        .o_quotient (div_quo),
        .o_stat     (div_stat)
    );

    assign o_out_valid     = r_o_valid;
    assign o_found         = r_o_found;
    assign o_low_div_shift = r_o_shift;
    assign o_high_div      = r_o_hs;
    assign o_feedback_div  = r_o_fb;

    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_high_div >= HS_MIN && o_high_div <= HS_MAX
            && o_low_div_shift <= SHIFT_LAST)
        else $error("divider plan out of range");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_low_div_shift == '0 && o_high_div == '0
            && o_feedback_div == '0)
        else $error("empty plan carries nonzero fields");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> r_state == ST_DIV0 || r_state == ST_DIV1)
        else $error("divider finished outside a division state");

    a_start_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> r_state == ST_IDLE || r_state == ST_CMP)
        else $error("divider started from wrong state");

endmodule
